@@ design/ftw_pkg.sv @@
// ----------------------------------------------------------------------------
// ftw_pkg
// shared types, character codes and the q32 scale table for the frequency
// text to tuning word unit
// ----------------------------------------------------------------------------
package ftw_pkg;

    localparam int MAX_DIGITS = 12;
    localparam longint unsigned MCLK_HZ = 64'd25000000;

    localparam int CHAR_W  = 8;
    localparam int MANT_W  = 40;
    localparam int WORD_W  = 28;
    localparam int DIGIT_W = $clog2(MAX_DIGITS + 1);

    // q32 scale is at most 2^60 for the slowest master clock
    localparam int SCALE_W     = 61;
    localparam int SCALE_BIAS  = MAX_DIGITS;
    localparam int SCALE_COUNT = MAX_DIGITS + 7;
    localparam int SCALE_IDX_W = $clog2(SCALE_COUNT);

    localparam int SUM_W = SCALE_W + 2;

    localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_KILO  = 8'h4B;
    localparam logic [CHAR_W-1:0] CHAR_MEGA  = 8'h4D;

    typedef enum logic [1:0] {
        SUFFIX_NONE = 2'd0,
        SUFFIX_KILO = 2'd1,
        SUFFIX_MEGA = 2'd2
    } suffix_t;

    typedef struct packed {
        logic [MANT_W-1:0]  mantissa;
        logic [SCALE_W-1:0] scale;
        logic               syntax_error;
        logic               overflow;
    } ftw_job_t;

    typedef logic [SCALE_W-1:0] scale_tab_t [SCALE_COUNT];

    // entry i holds floor(10^(i-bias) * 2^60 / mclk)
    function automatic scale_tab_t build_scale_table();
        scale_tab_t      tab;
        longint unsigned q;
        longint unsigned r;
        longint unsigned q0;
        longint unsigned r0;
        longint unsigned r10;
        int              k;
        int              i;
        q0 = (64'd1 << 60) / MCLK_HZ;
        r0 = (64'd1 << 60) % MCLK_HZ;
        for (int idx = 0; idx < SCALE_COUNT; idx++)
        begin
            k = idx - SCALE_BIAS;
            q = q0;
            r = r0;
            if (k >= 0)
            begin
                for (i = 0; i < k; i++)
                begin
                    r10 = r * 64'd10;
                    q   = q * 64'd10 + r10 / MCLK_HZ;
                    r   = r10 % MCLK_HZ;
                end
            end
            else
            begin
                for (i = 0; i > k; i--)
                begin
                    q = q / 64'd10;
                end
            end
            tab[idx] = q[SCALE_W-1:0];
        end
        return tab;
    endfunction

    localparam scale_tab_t SCALE_TABLE = build_scale_table();

endpackage

@@ design/ftw_parser.sv @@
// ----------------------------------------------------------------------------
// ftw_parser
// character input register and number syntax state; on the last character
// hands the mantissa, its q32 scale and the flags to the scaler
// ----------------------------------------------------------------------------
module ftw_parser
    import ftw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_last,
    output logic              job_valid,
    input  logic              job_ready,
    output ftw_job_t          job
);

    logic              a_valid_reg;
    logic [CHAR_W-1:0] a_char_reg;
    logic              a_last_reg;

    logic [MANT_W-1:0]  mantissa_reg;
    logic [MANT_W-1:0]  mantissa_next;
    logic [DIGIT_W-1:0] digit_count_reg;
    logic [DIGIT_W-1:0] digit_count_next;
    logic [DIGIT_W-1:0] fraction_digits_reg;
    logic [DIGIT_W-1:0] fraction_digits_next;
    suffix_t            suffix_reg;
    suffix_t            suffix_next;
    logic               after_point_reg;
    logic               after_point_next;
    logic               error_reg;
    logic               error_next;
    logic               overflow_reg;
    logic               overflow_next;

    logic     job_valid_reg;
    ftw_job_t job_reg;

    logic                   fire;
    logic                   job_free;
    logic [CHAR_W-1:0]      char_diff;
    logic [3:0]             digit;
    logic                   is_digit;
    logic                   room;
    logic [MANT_W-1:0]      mant_x10;
    logic [1:0]             suffix_bits;
    logic [SCALE_IDX_W-1:0] scale_idx;

    assign job_free = !job_valid_reg || job_ready;
    assign fire     = a_valid_reg && (!a_last_reg || job_free);
    assign in_ready = !a_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_char_reg <= in_char;
            a_last_reg <= in_last;
        end
    end

    assign char_diff = a_char_reg - CHAR_ZERO;
    assign digit     = char_diff[3:0];
    assign is_digit  = (a_char_reg >= CHAR_ZERO) && (a_char_reg <= CHAR_NINE);
    assign room      = digit_count_reg < DIGIT_W'(MAX_DIGITS);
    assign mant_x10  = (mantissa_reg << 3) + (mantissa_reg << 1)
                     + {{(MANT_W-4){1'b0}}, digit};

    always_comb
    begin
        mantissa_next        = mantissa_reg;
        digit_count_next     = digit_count_reg;
        fraction_digits_next = fraction_digits_reg;
        suffix_next          = suffix_reg;
        after_point_next     = after_point_reg;
        error_next           = error_reg;
        overflow_next        = overflow_reg;
        priority if (is_digit)
        begin
            if (!after_point_reg)
            begin
                // leading integer zeros are skipped
                if (mantissa_reg != '0 || digit != '0)
                begin
                    if (room)
                    begin
                        mantissa_next    = mant_x10;
                        digit_count_next = digit_count_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
            end
            else if (room)
            begin
                mantissa_next        = mant_x10;
                digit_count_next     = digit_count_reg + 1'b1;
                fraction_digits_next = fraction_digits_reg + 1'b1;
            end
        end
        else if (a_char_reg == CHAR_POINT)
        begin
            if (suffix_reg != SUFFIX_NONE || after_point_reg)
            begin
                error_next = 1'b1;
            end
            after_point_next = 1'b1;
        end
        else if (a_char_reg == CHAR_KILO || a_char_reg == CHAR_MEGA)
        begin
            if (suffix_reg != SUFFIX_NONE)
            begin
                error_next = 1'b1;
            end
            suffix_next      = (a_char_reg == CHAR_KILO) ? SUFFIX_KILO : SUFFIX_MEGA;
            after_point_next = 1'b1;
        end
        else
        begin
            error_next = 1'b1;
        end
    end

    // index = 3 * suffix - fraction digits + bias
    assign suffix_bits = suffix_next;
    assign scale_idx   = SCALE_IDX_W'(SCALE_BIAS)
                       + {{(SCALE_IDX_W-2){1'b0}}, suffix_bits}
                       + {{(SCALE_IDX_W-3){1'b0}}, suffix_bits, 1'b0}
                       - {{(SCALE_IDX_W-DIGIT_W){1'b0}}, fraction_digits_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mantissa_reg        <= '0;
            digit_count_reg     <= '0;
            fraction_digits_reg <= '0;
            suffix_reg          <= SUFFIX_NONE;
            after_point_reg     <= 1'b0;
            error_reg           <= 1'b0;
            overflow_reg        <= 1'b0;
        end
        else if (fire)
        begin
            if (a_last_reg)
            begin
                mantissa_reg        <= '0;
                digit_count_reg     <= '0;
                fraction_digits_reg <= '0;
                suffix_reg          <= SUFFIX_NONE;
                after_point_reg     <= 1'b0;
                error_reg           <= 1'b0;
                overflow_reg        <= 1'b0;
            end
            else
            begin
                mantissa_reg        <= mantissa_next;
                digit_count_reg     <= digit_count_next;
                fraction_digits_reg <= fraction_digits_next;
                suffix_reg          <= suffix_next;
                after_point_reg     <= after_point_next;
                error_reg           <= error_next;
                overflow_reg        <= overflow_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (fire && a_last_reg)
        begin
            job_valid_reg <= 1'b1;
        end
        else if (job_ready)
        begin
            job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && a_last_reg)
        begin
            job_reg.mantissa     <= mantissa_next;
            job_reg.scale        <= SCALE_TABLE[scale_idx];
            job_reg.syntax_error <= error_next;
            job_reg.overflow     <= overflow_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= DIGIT_W'(MAX_DIGITS))
        else $error("digit count beyond limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        fraction_digits_reg <= digit_count_reg)
        else $error("more fraction digits than digits");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && a_last_reg |=> mantissa_reg == '0 && digit_count_reg == '0
                               && !error_reg && !overflow_reg && job_valid_reg)
        else $error("state not cleared after last character");

endmodule

@@ design/ftw_scaler.sv @@
// ----------------------------------------------------------------------------
// ftw_scaler
// multiplies the mantissa by its q32 scale as registered partial products,
// then sums, saturates or zeroes on a syntax error, and holds the result beat
// ----------------------------------------------------------------------------
module ftw_scaler
    import ftw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  ftw_job_t          job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] tuning_word,
    output logic              syntax_error,
    output logic              overflow
);

    localparam int HI_W   = MANT_W - 32;
    localparam int T_HI_W = SCALE_W - 32;

    logic                    c_valid_reg;
    logic [63:0]             p_ll_reg;
    logic [HI_W+31:0]        p_hl_reg;
    logic [T_HI_W+31:0]      p_lh_reg;
    logic                    both_hi_reg;
    logic                    c_error_reg;
    logic                    c_overflow_reg;

    logic                    d_valid_reg;
    logic [WORD_W-1:0]       word_reg;
    logic                    error_reg;
    logic                    overflow_reg;

    logic [HI_W-1:0]   m_hi;
    logic [31:0]       m_lo;
    logic [T_HI_W-1:0] t_hi;
    logic [31:0]       t_lo;
    logic [63:0]       p_ll_next;
    logic [HI_W+31:0]  p_hl_next;
    logic [T_HI_W+31:0] p_lh_next;

    logic              d_free;
    logic              c_free;
    logic [SUM_W-1:0]  sum;
    logic              prod_sat;
    logic [WORD_W-1:0] word_next;
    logic              overflow_next;

    assign d_free    = !d_valid_reg || out_ready;
    assign c_free    = !c_valid_reg || d_free;
    assign job_ready = c_free;

    assign m_hi = job.mantissa[MANT_W-1:32];
    assign m_lo = job.mantissa[31:0];
    assign t_hi = job.scale[SCALE_W-1:32];
    assign t_lo = job.scale[31:0];

    assign p_ll_next = m_lo * t_lo;
    assign p_hl_next = m_hi * t_lo;
    assign p_lh_next = m_lo * t_hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_free)
        begin
            c_valid_reg <= job_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_free && job_valid)
        begin
            p_ll_reg       <= p_ll_next;
            p_hl_reg       <= p_hl_next;
            p_lh_reg       <= p_lh_next;
            both_hi_reg    <= (m_hi != '0) && (t_hi != '0);
            c_error_reg    <= job.syntax_error;
            c_overflow_reg <= job.overflow;
        end
    end

    assign sum = SUM_W'(p_lh_reg) + SUM_W'(p_hl_reg) + SUM_W'(p_ll_reg[63:32]);
    assign prod_sat = both_hi_reg || (sum > SUM_W'(WORD_MAX));

    always_comb
    begin
        overflow_next = c_overflow_reg;
        priority if (c_error_reg)
        begin
            word_next = '0;
        end
        else if (c_overflow_reg)
        begin
            word_next = WORD_MAX;
        end
        else if (prod_sat)
        begin
            word_next     = WORD_MAX;
            overflow_next = 1'b1;
        end
        else
        begin
            word_next = sum[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (d_free)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_free && c_valid_reg)
        begin
            word_reg     <= word_next;
            error_reg    <= c_error_reg;
            overflow_reg <= overflow_next;
        end
    end

    assign out_valid    = d_valid_reg;
    assign tuning_word  = word_reg;
    assign syntax_error = error_reg;
    assign overflow     = overflow_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && syntax_error |-> tuning_word == '0)
        else $error("nonzero word on syntax error");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !syntax_error && overflow |-> tuning_word == WORD_MAX)
        else $error("overflow without saturated word");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
                                    && $stable({tuning_word, syntax_error, overflow}))
        else $error("result beat changed while stalled");

endmodule

@@ design/frequency_text_to_tuning_word_unit.sv @@
// ----------------------------------------------------------------------------
// frequency_text_to_tuning_word_unit
// converts a frequency text such as 1.5K or 12.000M, one character per beat,
// into the 28-bit tuning word for a 25 MHz master clock
// ----------------------------------------------------------------------------
// One character is taken every clock cycle, but a last character is held in
// the input register while the stages behind it are full and the output is
// stalled. Each beat carries one upper-case ASCII character, tlast marks the
// final one, and only that beat produces a result beat: the word f * 2^28 /
// 25 MHz, truncated, 0 on a syntax error, saturated at 0xFFFFFFF with the
// overflow flag set when the integer part has more than 12 significant digits
// or the word does not fit. Fraction digits that would take the count of held
// digits past 12 are dropped. After the last character is taken, the result
// passes through the character parser with its multiply-by-ten accumulator,
// then the 32-bit partial products against the scale table, and then the sum
// and saturation into the output register.
module frequency_text_to_tuning_word_unit
    import ftw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // tuning_word, zero fill
    output logic [1:0]  m_axis_tuser    // overflow, syntax_error
);

    logic              job_valid;
    logic              job_ready;
    ftw_job_t          job;
    logic [WORD_W-1:0] tuning_word;
    logic              syntax_error;
    logic              overflow;

    ftw_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_char   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    ftw_scaler u_scaler (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .tuning_word  (tuning_word),
        .syntax_error (syntax_error),
        .overflow     (overflow)
    );

    assign m_axis_tdata = {{(32-WORD_W){1'b0}}, tuning_word};
    assign m_axis_tuser = {overflow, syntax_error};

endmodule
